/* src/assert_macros.svh */
// Assertion macros used by the RTL sequencer (shamd_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* src/shamd_pkg.sv */
// Types, constants and round functions for the SHA-256 digest block.
package shamd_pkg;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] H_INIT [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K_ROUND [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // Sequencer commands to the datapath
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       load_vars;
    logic       do_round;
    logic [5:0] rnd;
    logic       add_hash;
    logic       init_hash;
    logic [2:0] out_idx;
  } ctl_t;

  function automatic logic [31:0] big_sigma0(logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* src/shamd_core.sv */
// Datapath: block/schedule shift line, round unit, working and chaining registers.
module shamd_core
  import shamd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  output logic [31:0] digest_word_o
);

  logic [0:15][31:0] w_q, w_d;
  logic [0:7][31:0]  v_q, v_d;
  logic [31:0]       h_q [0:7];
  logic [31:0]       h_d [0:7];
  logic [511:0]      w_flat;
  logic [31:0]       w_new, t1, t2;
  logic [31:0]       va, vb, vc, vd, ve, vf, vg, vh;

  assign w_flat = w_q;
  assign {va, vb, vc, vd, ve, vf, vg, vh} = v_q;

  // one round per cycle
  assign w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
  assign t1 = vh + big_sigma1(ve) + ((ve & vf) ^ (~ve & vg)) + K_ROUND[ctl_i.rnd] + w_q[0];
  assign t2 = big_sigma0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));

  always_comb begin
    w_d = w_q;
    v_d = v_q;
    h_d = h_q;
    if (ctl_i.shift_byte) begin
      w_d = {w_flat[503:0], ctl_i.byte_val};
    end else if (ctl_i.do_round) begin
      w_d = {w_flat[479:0], w_new};
    end
    if (ctl_i.load_vars) begin
      v_d = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
    end else if (ctl_i.do_round) begin
      v_d = {t1 + t2, va, vb, vc, vd + t1, ve, vf, vg};
    end
    for (int i = 0; i < 8; i++) begin
      if (ctl_i.init_hash) begin
        h_d[i] = H_INIT[i];
      end else if (ctl_i.add_hash) begin
        h_d[i] = h_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    v_q <= v_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= H_INIT;
    end else begin
      h_q <= h_d;
    end
  end

  assign digest_word_o = h_q[ctl_i.out_idx];

endmodule

/* src/shamd_ctrl.sv */
// Sequencer: byte intake, padding, round counting and digest readout.
module shamd_ctrl
  import shamd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic [7:0] s_byte_i,
  input  logic       s_has_byte_i,
  input  logic       s_last_i,
  output logic       s_ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic       m_last_o,
  output ctl_t       ctl_o
);
`include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] cnt_q, cnt_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  oc_q, oc_d;
  logic        last_q, last_d;
  logic        pad80_q, pad80_d;
  logic        lenok_q, lenok_d;
  logic [63:0] bit_len;
  logic [2:0]  len_idx;
  logic        s_acc;

  assign bit_len = {cnt_q, 3'b000};
  assign len_idx = ~fill_q[2:0];
  assign s_acc   = s_valid_i && s_ready_o;

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = (state_q == ST_OUT);
  assign m_last_o  = (oc_q == 3'd7);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    rnd_d   = rnd_q;
    oc_d    = oc_q;
    last_d  = last_q;
    pad80_d = pad80_q;
    lenok_d = lenok_q;
    ctl_o   = '0;
    ctl_o.rnd     = rnd_q;
    ctl_o.out_idx = oc_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          last_d  = s_last_i;
          pad80_d = s_last_i;
          if (s_has_byte_i) begin
            ctl_o.shift_byte = 1'b1;
            ctl_o.byte_val   = s_byte_i;
            cnt_d = cnt_q + 61'd1;
            fill_d = fill_q + 6'd1;
            if (fill_q == 6'd63) begin
              state_d = ST_LOAD;
            end else if (s_last_i) begin
              state_d = ST_PAD;
            end
          end else if (s_last_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctl_o.shift_byte = 1'b1;
        if (pad80_q) begin
          ctl_o.byte_val = PAD_BYTE;
          pad80_d = 1'b0;
          lenok_d = (fill_q <= 6'd55);
        end else if (lenok_q && fill_q >= 6'd56) begin
          ctl_o.byte_val = bit_len[{len_idx, 3'b000} +: 8];
        end
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctl_o.load_vars = 1'b1;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        ctl_o.do_round = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        ctl_o.add_hash = 1'b1;
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (lenok_q) begin
          oc_d    = '0;
          state_d = ST_OUT;
        end else begin
          // padding spilled over: length goes in a block of its own
          if (!pad80_q) begin
            lenok_d = 1'b1;
          end
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (m_ready_i) begin
          oc_d = oc_q + 3'd1;
          if (oc_q == 3'd7) begin
            ctl_o.init_hash = 1'b1;
            fill_d  = '0;
            cnt_d   = '0;
            last_d  = 1'b0;
            pad80_d = 1'b0;
            lenok_d = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      rnd_q   <= '0;
      oc_q    <= '0;
      last_q  <= 1'b0;
      pad80_q <= 1'b0;
      lenok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      oc_q    <= oc_d;
      last_q  <= last_d;
      pad80_q <= pad80_d;
      lenok_q <= lenok_d;
    end
  end

  `ASSERT_NEVER(a_in_out_excl, s_ready_o && m_valid_o, "input and output open together")
  `ASSERT_AT(a_round_step, (state_q == ST_ROUND && rnd_q != 6'd63) |=> (state_q == ST_ROUND && rnd_q == 6'($past(rnd_q) + 6'd1)), "round counter skipped")
  `ASSERT_AT(a_out_hold, (state_q == ST_OUT && !(m_ready_i && oc_q == 3'd7)) |=> (state_q == ST_OUT), "digest readout cut short")
  `ASSERT_NEVER(a_len_after_pad, lenok_q && pad80_q, "length enabled before pad byte")

endmodule

/* src/sha256_message_digest.sv */
// SHA-256 message digest top level: stream ports around sequencer and datapath.
// Message bytes go in one item per cycle while the block is idle; the 64th byte of
// a block starts a compression that holds the input off (load, 64
// rounds on the single shared round unit, chaining add). An item with tlast set
// pads the message one byte per cycle through the same block shift line (up to
// 64 bytes, or up to 72 when the length spills into an extra block), runs the
// final compression(s), then presents the eight digest words, word 0 first,
// tlast on word 7, and reinitializes. Input stays stalled during readout.
module sha256_message_digest
  import shamd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // has_byte
  input  logic        s_axis_tlast_i,   // is_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_number
  output logic        m_axis_tlast_o    // final_word
);

  ctl_t        ctl;
  logic [31:0] digest_word;

  shamd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_byte_i     (s_axis_tdata_i),
    .s_has_byte_i (s_axis_tuser_i),
    .s_last_i     (s_axis_tlast_i),
    .s_ready_o    (s_axis_tready_o),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_last_o     (m_axis_tlast_o),
    .ctl_o        (ctl)
  );

  shamd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .digest_word_o (digest_word)
  );

  assign m_axis_tdata_o = {5'b00000, ctl.out_idx, digest_word};

endmodule

/* verif/sha256_digest_checker.sv */
// Checker for the SHA-256 digest block: predicts each digest from accepted bytes and compares.
`timescale 1ns / 100ps

module sha256_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // has_byte
  input  logic        s_axis_tlast_i,   // is_last
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,   // [31:0] digest_word, [34:32] word_number
  input  logic        m_axis_tlast_i,   // final_word
  output int          fail_count_o,
  output int          pending_o,
  output int          digest_count_o,
  output int          word_count_o
);

  localparam logic [7:0] MSG_PAD = 8'h80;

  localparam logic [31:0] IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last_word;
  } digest_word_t;

  logic [31:0]  chain_q [8];
  logic [7:0]   block_q [64];
  int unsigned  fill_q;
  logic [60:0]  byte_cnt_q;
  digest_word_t digest_words_q [$];

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void clear_message();
    for (int i = 0; i < 8; i++) chain_q[i] = IV[i];
    for (int i = 0; i < 64; i++) block_q[i] = 8'h00;
    fill_q     = 0;
    byte_cnt_q = '0;
  endfunction

  function automatic void absorb_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wr, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_q[4*i], block_q[4*i+1], block_q[4*i+2], block_q[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = chain_q[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        s0 = rotr(w[(r-15)&15], 7) ^ rotr(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
        s1 = rotr(w[(r-2)&15], 17) ^ rotr(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
        wr = w[r&15] + s0 + w[(r-7)&15] + s1;
        w[r&15] = wr;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] = chain_q[i] + v[i];
  endfunction

  function automatic void hash_item(logic [7:0] data, logic has_byte, logic is_last);
    logic [63:0]  bit_len;
    digest_word_t dw;
    if (has_byte) begin
      block_q[fill_q] = data;
      fill_q++;
      byte_cnt_q++;
      if (fill_q == 64) begin
        absorb_block();
        fill_q = 0;
      end
    end
    if (is_last) begin
      bit_len = {byte_cnt_q, 3'b000};
      block_q[fill_q] = MSG_PAD;
      fill_q++;
      // no room for the length: pad out this block and start another
      if (fill_q > 56) begin
        for (int i = fill_q; i < 64; i++) block_q[i] = 8'h00;
        absorb_block();
        fill_q = 0;
      end
      for (int i = fill_q; i < 56; i++) block_q[i] = 8'h00;
      for (int i = 0; i < 8; i++) block_q[63-i] = bit_len[8*i +: 8];
      absorb_block();
      for (int i = 0; i < 8; i++) begin
        dw.word      = chain_q[i];
        dw.idx       = 3'(i);
        dw.last_word = (i == 7);
        digest_words_q.push_back(dw);
      end
      digest_count_o++;
      clear_message();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t exp_w;
    if (!rst_ni) begin
      clear_message();
      digest_words_q.delete();
      fail_count_o   = 0;
      digest_count_o = 0;
      word_count_o   = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        word_count_o++;
        if (digest_words_q.size() == 0) begin
          $display("%0t: digest item with none expected, actual word %h idx %0d last %b",
                   $time, m_axis_tdata_i[31:0], m_axis_tdata_i[34:32], m_axis_tlast_i);
          fail_count_o++;
        end else begin
          exp_w = digest_words_q.pop_front();
          if (m_axis_tdata_i[31:0] !== exp_w.word) begin
            $display("%0t: digest_word mismatch, expected %h, actual %h",
                     $time, exp_w.word, m_axis_tdata_i[31:0]);
            fail_count_o++;
          end
          if (m_axis_tdata_i[34:32] !== exp_w.idx) begin
            $display("%0t: word_number mismatch, expected %0d, actual %0d",
                     $time, exp_w.idx, m_axis_tdata_i[34:32]);
            fail_count_o++;
          end
          if (m_axis_tlast_i !== exp_w.last_word) begin
            $display("%0t: final_word mismatch, expected %b, actual %b",
                     $time, exp_w.last_word, m_axis_tlast_i);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        hash_item(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
    end
    pending_o = digest_words_q.size();
  end

endmodule

/* verif/tb_sha256_message_digest.sv */
// Testbench top for the SHA-256 digest block: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_sha256_message_digest;

  localparam int ITEM_TARGET   = 230;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  int fail_count;
  int pending;
  int digest_count;
  int word_count;
  int items_sent;
  int bytes_sent;
  int stall_cycles;

  sha256_message_digest u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  sha256_digest_checker u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .digest_count_o  (digest_count),
    .word_count_o    (word_count)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // digest consumer: ready and stall runs, mostly short
  initial begin : rx_ready
    int run_left;
    int pick;
    m_tready = 1'b0;
    run_left = 0;
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          m_tready = 1'b1;
          run_left = $urandom_range(1, 12);
        end else if (pick < 60) begin
          m_tready = 1'b1;
          run_left = $urandom_range(40, 120);
        end else if (pick < 92) begin
          m_tready = 1'b0;
          run_left = $urandom_range(1, 3);
        end else begin
          m_tready = 1'b0;
          run_left = $urandom_range(10, 40);
        end
      end
      run_left--;
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input logic [7:0] data, input logic has_byte, input logic is_last,
                           input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = data;
    s_tuser  = has_byte;
    s_tlast  = is_last;
    do @(posedge clk_i); while (!s_tready);
    items_sent++;
    if (has_byte) bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // random content; ends either on the last byte or with a separate terminator
  task automatic send_message(input int len, input bit no_gaps);
    bit merge;
    merge = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, no_gaps);
      send_item(8'($urandom_range(0, 255)), 1'b1, merge && (i == len - 1), no_gaps);
    end
    if (!merge || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, no_gaps);
  endtask

  initial begin
    int len;
    int long_lens [5];
    long_lens    = '{55, 56, 63, 64, 65};
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tuser      = 1'b0;
    s_tlast      = 1'b0;
    items_sent   = 0;
    bytes_sent   = 0;
    stall_cycles = 0;
    rst_ni       = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty message, data byte ignored
    send_item(8'hff, 1'b0, 1'b1, 1'b0);
    // idle item, then a single zero byte carrying the end
    send_item(8'ha5, 1'b0, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1, 1'b0);
    // "abc" with an idle item inside and a separate terminator
    send_item(8'h61, 1'b1, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    // two empty messages back to back
    send_item(8'h00, 1'b0, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1, 1'b1);
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) len = long_lens[$urandom_range(0, 4)];
      else len = $urandom_range(0, 20);
      send_message(len, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Summary: %0d input items (%0d message bytes), %0d digests predicted,",
             items_sent, bytes_sent, digest_count);
    $display("         %0d digest words checked, boundary lengths 55/56/63/64/65 in the mix",
             word_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
